// File: hw/rtl/upq_pkg.sv
// Package for the unique priority queue: command codes, status codes and the
// small structs that pass between the top level and the cells of the chain.
// Depends on nothing.
package upq_pkg;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Command broadcast to every cell; already qualified by the duplicate, full and
   // empty checks, so a cell acts on it without further tests.
   typedef struct packed {
      logic insert;
      logic remove;
   } cmd_ctl_type;

   // What a cell tells its neighbors about itself.
   typedef struct packed {
      logic valid;
      logic ahead;
   } link_type;

endpackage

// File: hw/rtl/upq_cell.sv
// One cell of the sorted chain: holds one entry and moves it to a neighbor.
// Depends on upq_pkg.
module upq_cell #(
   parameter int PRIO_BITS    = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  upq_pkg::cmd_ctl_type        ctl,
   input  logic [PRIO_BITS-1:0]        new_prio,
   input  logic [PAYLOAD_BITS-1:0]     new_payload,
   input  upq_pkg::link_type           left_link,
   input  logic [PRIO_BITS-1:0]        left_prio,
   input  logic [PAYLOAD_BITS-1:0]     left_payload,
   input  logic                        right_valid,
   input  logic [PRIO_BITS-1:0]        right_prio,
   input  logic [PAYLOAD_BITS-1:0]     right_payload,
   output upq_pkg::link_type           cell_link,
   output logic [PRIO_BITS-1:0]        cell_prio,
   output logic [PAYLOAD_BITS-1:0]     cell_payload,
   output logic                        cell_dup
);
   import upq_pkg::*;

   logic                    valid_ff, valid_in;
   logic [PRIO_BITS-1:0]    prio_ff, prio_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic                    ahead;

   // The new entry belongs at or above this cell when the cell is empty or
   // holds a lower priority.
   assign ahead = !valid_ff || (new_prio > prio_ff);

   always_comb begin
      valid_in   = valid_ff;
      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (ctl.insert && ahead) begin
         if (left_link.ahead) begin
            valid_in   = left_link.valid;
            prio_in    = left_prio;
            payload_in = left_payload;
         end else begin
            valid_in   = 1'b1;
            prio_in    = new_prio;
            payload_in = new_payload;
         end
      end else if (ctl.remove) begin
         valid_in   = right_valid;
         prio_in    = right_prio;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

   assign cell_link.valid = valid_ff;
   assign cell_link.ahead = ahead;
   assign cell_prio       = prio_ff;
   assign cell_payload    = payload_ff;
   assign cell_dup        = valid_ff && (prio_ff == new_prio);

endmodule

// File: hw/rtl/unique_priority_queue.sv
// Top level of the unique priority queue: the cell chain, the command checks,
// the entry count and the response registers. Depends on upq_pkg, upq_cell.
//
// The queue holds up to DEPTH entries, each a priority and a payload, kept
// sorted by descending priority with no two entries sharing a priority. A word
// is accepted on every clock edge where start is high and busy is low; busy is
// always low, so the queue takes one command per cycle. Each command gives
// exactly one response word, shown with rsp_strobe for the single cycle right
// after the command was accepted. The receiver cannot stall, so it must sample
// the response in that cycle. The head, count and empty fields reflect the
// queue after the command. An insert of a priority already held reports a
// duplicate and changes nothing; this check wins over the full check. A remove
// on an empty queue reports empty with zero removed fields.
module unique_priority_queue #(
   parameter int DEPTH        = 16,
   parameter int PRIO_BITS    = 16,
   parameter int PAYLOAD_BITS = 32,
   localparam int CNT_W       = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_cmd,
   input  logic [PRIO_BITS-1:0]     req_priority_req,
   input  logic [PAYLOAD_BITS-1:0]  req_payload,
   output logic                     rsp_strobe,
   output logic [1:0]               rsp_status,
   output logic [PRIO_BITS-1:0]     rsp_removed_priority,
   output logic [PAYLOAD_BITS-1:0]  rsp_removed_payload,
   output logic [PRIO_BITS-1:0]     rsp_head_priority,
   output logic [PAYLOAD_BITS-1:0]  rsp_head_payload,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic                     rsp_is_vacant
);
   import upq_pkg::*;

   link_type                cell_link    [DEPTH];
   logic [PRIO_BITS-1:0]    cell_prio    [DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
   logic [DEPTH-1:0]        cell_dup;

   cmd_ctl_type ctl;
   logic        accept;
   logic        dup_any;
   logic        full;
   logic        empty;
   status_type  status;

   logic                    strobe_ff;
   status_type              status_ff, status_in;
   logic [PRIO_BITS-1:0]    rem_prio_ff, rem_prio_in;
   logic [PAYLOAD_BITS-1:0] rem_payload_ff, rem_payload_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   // Every command finishes in the cycle it is accepted.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Duplicate search runs over all cells at once; the chain is packed, so
   // the last cell is valid exactly when the queue is full.
   assign dup_any = |cell_dup;
   assign full    = cell_link[DEPTH-1].valid;
   assign empty   = !cell_link[0].valid;

   always_comb begin
      ctl.insert     = 1'b0;
      ctl.remove     = 1'b0;
      status         = ST_DONE;
      rem_prio_in    = '0;
      rem_payload_in = '0;
      count_in       = count_ff;
      if (req_cmd == CMD_INSERT) begin
         if (dup_any) begin
            status = ST_DUP;
         end else if (full) begin
            status = ST_FULL;
         end else begin
            ctl.insert = accept;
            count_in   = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            status = ST_EMPTY;
         end else begin
            ctl.remove     = accept;
            rem_prio_in    = cell_prio[0];
            rem_payload_in = cell_payload[0];
            count_in       = count_ff - CNT_W'(1);
         end
      end
      status_in = status;
   end

   // The chain: each cell sees its upper neighbor for shifting down on insert
   // and its lower neighbor for shifting up on remove.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      link_type                left_link;
      logic [PRIO_BITS-1:0]    left_prio;
      logic [PAYLOAD_BITS-1:0] left_payload;
      logic                    right_valid;
      logic [PRIO_BITS-1:0]    right_prio;
      logic [PAYLOAD_BITS-1:0] right_payload;

      if (i == 0) begin : g_first
         assign left_link.valid = 1'b1;
         assign left_link.ahead = 1'b0;
         assign left_prio       = '0;
         assign left_payload    = '0;
      end else begin : g_inner_left
         assign left_link    = cell_link[i-1];
         assign left_prio    = cell_prio[i-1];
         assign left_payload = cell_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_valid   = 1'b0;
         assign right_prio    = '0;
         assign right_payload = '0;
      end else begin : g_inner_right
         assign right_valid   = cell_link[i+1].valid;
         assign right_prio    = cell_prio[i+1];
         assign right_payload = cell_payload[i+1];
      end

      upq_cell #(
         .PRIO_BITS    (PRIO_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .new_prio      (req_priority_req),
         .new_payload   (req_payload),
         .left_link     (left_link),
         .left_prio     (left_prio),
         .left_payload  (left_payload),
         .right_valid   (right_valid),
         .right_prio    (right_prio),
         .right_payload (right_payload),
         .cell_link     (cell_link[i]),
         .cell_prio     (cell_prio[i]),
         .cell_payload  (cell_payload[i]),
         .cell_dup      (cell_dup[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         rem_prio_ff    <= rem_prio_in;
         rem_payload_ff <= rem_payload_in;
      end
   end

   // Head comes straight from the chain and count from the count register; both
   // already hold the state after the command while the strobe is high.
   assign rsp_strobe           = strobe_ff;
   assign rsp_status           = status_ff;
   assign rsp_removed_priority = rem_prio_ff;
   assign rsp_removed_payload  = rem_payload_ff;
   assign rsp_head_priority    = cell_link[0].valid ? cell_prio[0] : '0;
   assign rsp_head_payload     = cell_link[0].valid ? cell_payload[0] : '0;
   assign rsp_entry_count      = count_ff;
   assign rsp_is_vacant        = (count_ff == '0);

endmodule

// File: hw/rtl/upq_checker.sv
// Port-level checks for the unique priority queue, bound to the top level.
// Depends on upq_pkg and unique_priority_queue.
module upq_checker #(
   parameter int DEPTH        = 16,
   parameter int PRIO_BITS    = 16,
   parameter int PAYLOAD_BITS = 32,
   localparam int CNT_W       = $clog2(DEPTH + 1)
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    req_cmd,
   input logic                    rsp_strobe,
   input logic [1:0]              rsp_status,
   input logic [PRIO_BITS-1:0]    rsp_removed_priority,
   input logic [PRIO_BITS-1:0]    rsp_head_priority,
   input logic [CNT_W-1:0]        rsp_entry_count,
   input logic                    rsp_is_vacant
);
   import upq_pkg::*;

   // Every accepted command gives one response in the next cycle.
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("accepted command gave no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("response without a command");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_DONE && $past(req_cmd) == CMD_INSERT)
      |-> rsp_entry_count == $past(rsp_entry_count) + CNT_W'(1))
      else $error("successful insert did not raise the count");

   a_reject_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_DONE)
      |-> rsp_entry_count == $past(rsp_entry_count))
      else $error("rejected command changed the count");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_EMPTY)
      |-> (rsp_is_vacant && rsp_removed_priority == '0 && rsp_head_priority == '0))
      else $error("empty response with nonzero fields");

endmodule

bind unique_priority_queue upq_checker #(
   .DEPTH        (DEPTH),
   .PRIO_BITS    (PRIO_BITS),
   .PAYLOAD_BITS (PAYLOAD_BITS)
) u_upq_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_cmd              (req_cmd),
   .rsp_strobe           (rsp_strobe),
   .rsp_status           (rsp_status),
   .rsp_removed_priority (rsp_removed_priority),
   .rsp_head_priority    (rsp_head_priority),
   .rsp_entry_count      (rsp_entry_count),
   .rsp_is_vacant        (rsp_is_vacant)
);
